[src/lcml_pkg.sv]
// Shared types and constants for the load-cell mass interpolation core.
// No dependencies.
package lcml_pkg;

    localparam int MASS_W   = 32;
    localparam int FACTOR_W = 32;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 32;
    localparam int QUO_BITS = 33;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_DISABLED    = 3'd1,
        ST_COINCIDENT  = 3'd2,
        ST_ZERO_FACTOR = 3'd3,
        ST_SATURATED   = 3'd4
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLED     = 4'd0,
        CFG_ZERO_OFFSET = 4'd1,
        CFG_READING_0   = 4'd2,
        CFG_READING_1   = 4'd3,
        CFG_READING_2   = 4'd4,
        CFG_FACTOR_0    = 4'd5,
        CFG_FACTOR_1    = 4'd6,
        CFG_FACTOR_2    = 4'd7
    } cfg_idx_t;

    typedef struct packed {
        logic en;
        logic coinc;
        logic zero_factor;
        logic factor_sat;
    } flags_t;

endpackage

[src/lcml_poly.sv]
// Seven-stage pipeline forming the Lagrange numerator and denominator, and the
// split multiplier it is built from (registered partial products, then a registered sum). Depends on lcml_pkg.
module lcml_mul #(
    parameter int AW = 57,
    parameter int BW = 25
) (
    input  logic                    clk,
    input  logic signed [AW-1:0]    a,
    input  logic signed [BW-1:0]    b,
    output logic signed [AW+BW-1:0] p
);
    localparam int NC  = (AW + 31) / 32;
    localparam int PPW = 33 + BW;
    localparam int RW  = AW + BW;

    logic signed [32:0]    part   [NC];
    logic signed [PPW-1:0] pp_reg [NC];
    logic signed [RW-1:0]  sum_next;
    logic signed [RW-1:0]  p_reg;

    // Low slices are unsigned, the top slice carries the sign
    for (genvar k = 0; k < NC; k++)
    begin : g_part
        if (k == NC - 1)
        begin : g_top
            assign part[k] = 33'($signed(a[AW-1:32*k]));
        end
        else
        begin : g_low
            assign part[k] = {1'b0, a[32*k+31:32*k]};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NC; k++)
        begin
            pp_reg[k] <= part[k] * b;
        end
    end

    always_comb
    begin
        sum_next = '0;
        for (int k = 0; k < NC; k++)
        begin
            sum_next = sum_next + (RW'(pp_reg[k]) <<< (32 * k));
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg <= sum_next;
    end

    assign p = p_reg;

endmodule

module lcml_poly #(
    parameter int ADC_BITS = 24
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_vld,
    input  logic signed [ADC_BITS-1:0]            x,
    input  logic signed [ADC_BITS-1:0]            zero_offset,
    input  logic signed [ADC_BITS-1:0]            r0,
    input  logic signed [ADC_BITS-1:0]            r1,
    input  logic signed [ADC_BITS-1:0]            r2,
    input  logic signed [lcml_pkg::FACTOR_W-1:0]  y0,
    input  logic signed [lcml_pkg::FACTOR_W-1:0]  y1,
    input  logic signed [lcml_pkg::FACTOR_W-1:0]  y2,
    input  logic                                  en,
    output logic                                  out_vld,
    output logic signed [3*ADC_BITS+lcml_pkg::FACTOR_W+4:0] num,
    output logic signed [3*ADC_BITS+2:0]          den,
    output logic signed [ADC_BITS:0]              xz,
    output logic                                  out_en,
    output logic                                  out_coinc
);
    import lcml_pkg::*;

    localparam int DW  = ADC_BITS + 1;
    localparam int AW1 = FACTOR_W + DW;
    localparam int AW2 = FACTOR_W + 2 * DW;
    localparam int PW  = FACTOR_W + 3 * DW;
    localparam int NW  = PW + 2;
    localparam int VW  = 3 * DW;
    localparam int NS  = 7;

    logic [NS-1:0] vld_reg, en_reg, coinc_reg;

    logic signed [DW-1:0] a0_reg, a1_reg, a2_reg, d01_reg, d02_reg, d12_reg;
    logic signed [DW-1:0] a1b_reg, a2b_reg, d01b_reg, d02b_reg, d12b_reg;
    logic signed [DW-1:0] d01c_reg, d02c_reg, d12c_reg, d01d_reg, d02d_reg, d12d_reg;
    logic signed [DW-1:0] xz_reg [NS];
    logic signed [FACTOR_W-1:0] y0_reg, y1_reg, y2_reg;
    logic signed [AW1-1:0] p0a_reg, p1a_reg, p2a_reg;
    logic signed [AW2-1:0] p0b, p1b, p2b;
    logic signed [PW-1:0] p0c, p1c, p2c;
    logic signed [2*DW-1:0] v1_reg;
    logic signed [VW-1:0] v2, v3_reg, v4_reg, v5_reg;
    logic signed [NW-1:0] n_reg;

    logic signed [DW-1:0] d01_next, d02_next, d12_next;

    assign d01_next = DW'(r0) - DW'(r1);
    assign d02_next = DW'(r0) - DW'(r2);
    assign d12_next = DW'(r1) - DW'(r2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[NS-2:0], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        a0_reg    <= DW'(x) - DW'(r0);
        a1_reg    <= DW'(x) - DW'(r1);
        a2_reg    <= DW'(x) - DW'(r2);
        d01_reg   <= d01_next;
        d02_reg   <= d02_next;
        d12_reg   <= d12_next;
        xz_reg[0] <= DW'(x) - DW'(zero_offset);
        y0_reg    <= y0;
        y1_reg    <= y1;
        y2_reg    <= y2;
        en_reg[0] <= en;
        coinc_reg[0] <= (d01_next == '0) || (d02_next == '0) || (d12_next == '0);

        p0a_reg  <= y0_reg * a1_reg;
        p1a_reg  <= y1_reg * a0_reg;
        p2a_reg  <= y2_reg * a0_reg;
        v1_reg   <= d01_reg * d02_reg;
        a2b_reg  <= a2_reg;
        a1b_reg  <= a1_reg;
        d01b_reg <= d01_reg;
        d02b_reg <= d02_reg;
        d12b_reg <= d12_reg;

        d01c_reg <= d01b_reg;
        d02c_reg <= d02b_reg;
        d12c_reg <= d12b_reg;
        d01d_reg <= d01c_reg;
        d02d_reg <= d02c_reg;
        d12d_reg <= d12c_reg;

        v3_reg   <= v2;
        v4_reg   <= v3_reg;
        v5_reg   <= v4_reg;

        n_reg    <= NW'(p0c) - NW'(p1c) + NW'(p2c);

        for (int i = 1; i < NS; i++)
        begin
            xz_reg[i] <= xz_reg[i-1];
        end
        en_reg[NS-1:1]    <= en_reg[NS-2:0];
        coinc_reg[NS-1:1] <= coinc_reg[NS-2:0];
    end

    lcml_mul #(.AW (AW1), .BW (DW)) u_mul_p0b (.clk (clk), .a (p0a_reg), .b (a2b_reg), .p (p0b));
    lcml_mul #(.AW (AW1), .BW (DW)) u_mul_p1b (.clk (clk), .a (p1a_reg), .b (a2b_reg), .p (p1b));
    lcml_mul #(.AW (AW1), .BW (DW)) u_mul_p2b (.clk (clk), .a (p2a_reg), .b (a1b_reg), .p (p2b));
    lcml_mul #(.AW (2 * DW), .BW (DW)) u_mul_v2 (.clk (clk), .a (v1_reg), .b (d12b_reg), .p (v2));

    lcml_mul #(.AW (AW2), .BW (DW)) u_mul_p0c (.clk (clk), .a (p0b), .b (d12d_reg), .p (p0c));
    lcml_mul #(.AW (AW2), .BW (DW)) u_mul_p1c (.clk (clk), .a (p1b), .b (d02d_reg), .p (p1c));
    lcml_mul #(.AW (AW2), .BW (DW)) u_mul_p2c (.clk (clk), .a (p2b), .b (d01d_reg), .p (p2c));

    assign out_vld   = vld_reg[NS-1];
    assign num       = n_reg;
    assign den       = v5_reg;
    assign xz        = xz_reg[NS-1];
    assign out_en    = en_reg[NS-1];
    assign out_coinc = coinc_reg[NS-1];

endmodule

[src/lcml_div.sv]
// Pipelined signed divider, one quotient bit per stage, rounded half away from
// zero and saturated to 32 bits. Depends on lcml_pkg.
module lcml_div #(
    parameter int NW = 64,
    parameter int DW = 32,
    parameter int SW = 1
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_vld,
    input  logic signed [NW-1:0]              num,
    input  logic signed [DW-1:0]              den,
    input  logic [SW-1:0]                     sb_in,
    output logic                              out_vld,
    output logic signed [lcml_pkg::MASS_W-1:0] quo,
    output logic                              sat,
    output logic [SW-1:0]                     sb_out
);
    import lcml_pkg::*;

    localparam int QB = QUO_BITS;
    localparam int W  = ((NW > DW + QB) ? NW : DW + QB) + 1;
    localparam int LAST = QB;

    logic [QB+1:0]  vld_reg;
    logic [W-1:0]   r_reg   [QB+1];
    logic [QB-1:0]  q_reg   [QB+1];
    logic [DW-1:0]  d_reg   [QB+1];
    logic           neg_reg [QB+1];
    logic           ovf_reg [QB+1];
    logic [SW-1:0]  sb_reg  [QB+1];

    logic [NW-1:0]  nm_next;
    logic [DW-1:0]  dm_next;

    logic               rnd_next;
    logic [QB:0]        qr_next;
    logic signed [QB+1:0] qs_next;
    logic               fits_next;
    logic               sat_next;

    logic signed [MASS_W-1:0] quo_reg;
    logic                     sat_reg;
    logic [SW-1:0]            sbo_reg;

    assign nm_next = num[NW-1] ? NW'(-num) : NW'(num);
    assign dm_next = den[DW-1] ? DW'(-den) : DW'(den);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[QB:0], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg[0]   <= W'(nm_next);
        q_reg[0]   <= '0;
        d_reg[0]   <= dm_next;
        neg_reg[0] <= num[NW-1] ^ den[DW-1];
        ovf_reg[0] <= W'(nm_next) >= (W'(dm_next) << QB);
        sb_reg[0]  <= sb_in;
    end

    for (genvar k = 0; k < QB; k++)
    begin : g_stage
        localparam int B = QB - 1 - k;
        logic [W-1:0] sh;
        logic         ge;

        assign sh = W'(d_reg[k]) << B;
        assign ge = r_reg[k] >= sh;

        always_ff @(posedge clk)
        begin
            r_reg[k+1]   <= ge ? r_reg[k] - sh : r_reg[k];
            q_reg[k+1]   <= q_reg[k] | (QB'(ge) << B);
            d_reg[k+1]   <= d_reg[k];
            neg_reg[k+1] <= neg_reg[k];
            ovf_reg[k+1] <= ovf_reg[k];
            sb_reg[k+1]  <= sb_reg[k];
        end
    end

    assign rnd_next  = {r_reg[LAST], 1'b0} >= (W + 1)'(d_reg[LAST]);
    assign qr_next   = (QB + 1)'(q_reg[LAST]) + (QB + 1)'(rnd_next);
    assign qs_next   = neg_reg[LAST] ? -$signed((QB + 2)'(qr_next))
                                     : $signed((QB + 2)'(qr_next));
    assign fits_next = (&qs_next[QB+1:MASS_W-1]) | ~(|qs_next[QB+1:MASS_W-1]);
    assign sat_next  = ovf_reg[LAST] | ~fits_next;

    always_ff @(posedge clk)
    begin
        sat_reg <= sat_next;
        sbo_reg <= sb_reg[LAST];
        if (sat_next)
        begin
            quo_reg <= neg_reg[LAST] ? {1'b1, {(MASS_W - 1){1'b0}}}
                                     : {1'b0, {(MASS_W - 1){1'b1}}};
        end
        else
        begin
            quo_reg <= qs_next[MASS_W-1:0];
        end
    end

    assign out_vld = vld_reg[QB+1];
    assign quo     = quo_reg;
    assign sat     = sat_reg;
    assign sb_out  = sbo_reg;

endmodule

[src/load_cell_mass_lagrange_core.sv]
// Top level of the load-cell mass core: configuration registers, the polynomial
// pipeline and two pipelined dividers. Depends on lcml_pkg, lcml_poly, lcml_div.
//
// One reading is taken on every cycle that start is high; busy never rises.
// Each reading gives one result on done, through seven pipeline stages for the
// Lagrange numerator and denominator, then two dividers that each resolve one
// quotient bit per stage, then the output register. Results cannot be held off.
// Write configuration only while no reading is in flight.
module load_cell_mass_lagrange_core #(
    parameter int FRAC_BITS = 16,
    parameter int ADC_BITS  = 24
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [ADC_BITS-1:0]           adc_average,
    output logic                                 done,
    output logic signed [lcml_pkg::MASS_W-1:0]   mass,
    output logic [2:0]                           status,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [lcml_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [lcml_pkg::CFG_DAT_W-1:0]       cfg_data
);
    import lcml_pkg::*;

    localparam int DW   = ADC_BITS + 1;
    localparam int NW1  = 3 * ADC_BITS + FACTOR_W + 5;
    localparam int VW   = 3 * ADC_BITS + 3;
    localparam int NW2  = DW + 2 * FRAC_BITS;
    localparam int SW1  = DW + 2;
    localparam int LAT  = 8 + 2 * (QUO_BITS + 2);

    logic                       enabled_reg;
    logic signed [ADC_BITS-1:0] zero_offset_reg, r0_reg, r1_reg, r2_reg;
    logic signed [FACTOR_W-1:0] y0_reg, y1_reg, y2_reg;

    logic                       p_vld, p_en, p_coinc;
    logic signed [NW1-1:0]      p_num;
    logic signed [VW-1:0]       p_den;
    logic signed [DW-1:0]       p_xz;

    logic                       f_vld, f_sat;
    logic signed [MASS_W-1:0]   f_quo;
    logic [SW1-1:0]             f_sb;
    logic signed [DW-1:0]       f_xz;
    flags_t                     f_flags;
    logic signed [NW2-1:0]      m_num;

    logic                       m_vld, m_sat;
    logic signed [MASS_W-1:0]   m_quo;
    flags_t                     m_flags;

    status_t                    status_next;
    logic signed [MASS_W-1:0]   mass_next;
    logic                       done_reg;
    status_t                    status_reg;
    logic signed [MASS_W-1:0]   mass_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg     <= 1'b0;
            zero_offset_reg <= '0;
            r0_reg          <= ADC_BITS'(0);
            r1_reg          <= ADC_BITS'(1);
            r2_reg          <= ADC_BITS'(2);
            y0_reg          <= FACTOR_W'(65536);
            y1_reg          <= FACTOR_W'(65536);
            y2_reg          <= FACTOR_W'(65536);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_ENABLED:     enabled_reg     <= cfg_data[0];
                CFG_ZERO_OFFSET: zero_offset_reg <= cfg_data[ADC_BITS-1:0];
                CFG_READING_0:   r0_reg          <= cfg_data[ADC_BITS-1:0];
                CFG_READING_1:   r1_reg          <= cfg_data[ADC_BITS-1:0];
                CFG_READING_2:   r2_reg          <= cfg_data[ADC_BITS-1:0];
                CFG_FACTOR_0:    y0_reg          <= cfg_data[FACTOR_W-1:0];
                CFG_FACTOR_1:    y1_reg          <= cfg_data[FACTOR_W-1:0];
                CFG_FACTOR_2:    y2_reg          <= cfg_data[FACTOR_W-1:0];
                default:         ;
            endcase
        end
    end

    lcml_poly #(
        .ADC_BITS (ADC_BITS)
    ) u_poly (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_vld      (start && !busy),
        .x           (adc_average),
        .zero_offset (zero_offset_reg),
        .r0          (r0_reg),
        .r1          (r1_reg),
        .r2          (r2_reg),
        .y0          (y0_reg),
        .y1          (y1_reg),
        .y2          (y2_reg),
        .en          (enabled_reg),
        .out_vld     (p_vld),
        .num         (p_num),
        .den         (p_den),
        .xz          (p_xz),
        .out_en      (p_en),
        .out_coinc   (p_coinc)
    );

    lcml_div #(
        .NW (NW1),
        .DW (VW),
        .SW (SW1)
    ) u_div_factor (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (p_vld),
        .num     (p_num),
        .den     (p_den),
        .sb_in   ({p_xz, p_en, p_coinc}),
        .out_vld (f_vld),
        .quo     (f_quo),
        .sat     (f_sat),
        .sb_out  (f_sb)
    );

    assign f_xz                = f_sb[SW1-1:2];
    assign f_flags.en          = f_sb[1];
    assign f_flags.coinc       = f_sb[0];
    assign f_flags.zero_factor = (f_quo == '0);
    assign f_flags.factor_sat  = f_sat;
    assign m_num               = {f_xz, {(2 * FRAC_BITS){1'b0}}};

    lcml_div #(
        .NW (NW2),
        .DW (MASS_W),
        .SW ($bits(flags_t))
    ) u_div_mass (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (f_vld),
        .num     (m_num),
        .den     (f_quo),
        .sb_in   (f_flags),
        .out_vld (m_vld),
        .quo     (m_quo),
        .sat     (m_sat),
        .sb_out  (m_flags)
    );

    always_comb
    begin
        mass_next = '0;
        priority if (!m_flags.en)
        begin
            status_next = ST_DISABLED;
        end
        else if (m_flags.coinc)
        begin
            status_next = ST_COINCIDENT;
        end
        else if (m_flags.zero_factor)
        begin
            status_next = ST_ZERO_FACTOR;
        end
        else
        begin
            mass_next   = m_quo;
            status_next = (m_flags.factor_sat || m_sat) ? ST_SATURATED : ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= m_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        mass_reg   <= mass_next;
    end

    assign done   = done_reg;
    assign mass   = mass_reg;
    assign status = status_reg;

`ifndef ASSERT_OFF
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##LAT done)
        else $error("transfer result missing at expected latency");
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result without accepted transfer");
    a_zero_mass: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status == ST_DISABLED || status == ST_COINCIDENT ||
                 status == ST_ZERO_FACTOR) |-> mass == '0)
        else $error("nonzero mass on error status");
`endif

endmodule

[test/tb_load_cell_mass_lagrange_core.sv]
// Testbench for load_cell_mass_lagrange_core: drives readings and register writes.
// It predicts mass and status at full precision and checks each result on done.
// Depends on lcml_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_load_cell_mass_lagrange_core;
    import lcml_pkg::*;

    localparam int FRAC    = 16;
    localparam int ADC_W   = 24;
    localparam int LATENCY = 80;
    localparam int LIMIT   = 400000;

    typedef struct {
        logic signed [MASS_W-1:0] mass;
        status_t                  status;
    } mass_result_t;

    logic                    clk;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    logic signed [ADC_W-1:0] adc_average;
    logic                    done;
    logic signed [MASS_W-1:0] mass;
    logic [2:0]              status;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DAT_W-1:0]    cfg_data;

    // Mirror of the register file
    logic                    reg_en;
    logic signed [ADC_W-1:0] reg_zero;
    logic signed [ADC_W-1:0] reg_rd [3];
    logic signed [31:0]      reg_fac [3];

    mass_result_t pending_masses[$];
    int unsigned  mismatches;
    int unsigned  cycles;

    load_cell_mass_lagrange_core #(.FRAC_BITS(FRAC), .ADC_BITS(ADC_W)) u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .adc_average(adc_average), .done(done), .mass(mass), .status(status),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic signed [255:0] div_nearest(input logic signed [255:0] a,
                                                        input logic signed [255:0] b);
        logic                 neg;
        logic signed [255:0]  q;
        logic signed [255:0]  r;
        neg = (a < 0) != (b < 0);
        if (a < 0) a = -a;
        if (b < 0) b = -b;
        q = a / b;
        r = a - q * b;
        if (2 * r >= b) q = q + 1;
        return neg ? -q : q;
    endfunction

    function automatic logic signed [31:0] clamp32(input logic signed [255:0] v,
                                                  inout logic sat);
        if (v > 256'sh7FFFFFFF)
        begin
            sat = 1'b1;
            return 32'sh7FFFFFFF;
        end
        if (v < -256'sh80000000)
        begin
            sat = 1'b1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic mass_result_t predict_mass(input logic signed [ADC_W-1:0] x);
        mass_result_t        e;
        logic signed [255:0] wx, r0, r1, r2, d01, d02, d12, v, n, f, num, m;
        logic signed [255:0] y0, y1, y2, zo;
        logic signed [31:0]  fq;
        logic                sat;
        e.mass = '0;
        sat = 1'b0;
        if (!reg_en)
        begin
            e.status = ST_DISABLED;
            return e;
        end
        wx = x;
        r0 = reg_rd[0];
        r1 = reg_rd[1];
        r2 = reg_rd[2];
        y0 = reg_fac[0];
        y1 = reg_fac[1];
        y2 = reg_fac[2];
        zo = reg_zero;
        d01 = r0 - r1;
        d02 = r0 - r2;
        d12 = r1 - r2;
        if (d01 == 0 || d02 == 0 || d12 == 0)
        begin
            e.status = ST_COINCIDENT;
            return e;
        end
        v = d01 * d02 * d12;
        n = y0 * (wx - r1) * (wx - r2) * d12
          - y1 * (wx - r0) * (wx - r2) * d02
          + y2 * (wx - r0) * (wx - r1) * d01;
        f = div_nearest(n, v);
        fq = clamp32(f, sat);
        if (fq == 0)
        begin
            e.status = ST_ZERO_FACTOR;
            return e;
        end
        num = (wx - zo) <<< (2 * FRAC);
        m = div_nearest(num, 256'(fq));
        e.mass = clamp32(m, sat);
        e.status = sat ? ST_SATURATED : ST_OK;
        return e;
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        mass_result_t e;
        if (rst_n && done)
        begin
            if (pending_masses.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result mass=%0d status=%0d", mass, status);
            end
            else
            begin
                e = pending_masses.pop_front();
                if (mass !== e.mass || status !== e.status)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected mass=%0d status=%0d, got mass=%0d status=%0d",
                                 e.mass, e.status, mass, status);
                end
            end
        end
    end

    task automatic send_reading(input logic signed [ADC_W-1:0] x);
        start <= 1'b1;
        adc_average <= x;
        do
            @(posedge clk);
        while (busy);
        pending_masses.push_back(predict_mass(x));
    endtask

    task automatic pause(input int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_masses.size() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DAT_W-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_ENABLED:     reg_en = d[0];
            CFG_ZERO_OFFSET: reg_zero = d[ADC_W-1:0];
            CFG_READING_0:   reg_rd[0] = d[ADC_W-1:0];
            CFG_READING_1:   reg_rd[1] = d[ADC_W-1:0];
            CFG_READING_2:   reg_rd[2] = d[ADC_W-1:0];
            CFG_FACTOR_0:    reg_fac[0] = d;
            CFG_FACTOR_1:    reg_fac[1] = d;
            CFG_FACTOR_2:    reg_fac[2] = d;
            default:         ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_all(input logic en, input logic [31:0] zo,
                            input logic [31:0] c0, input logic [31:0] c1,
                            input logic [31:0] c2, input logic [31:0] f0,
                            input logic [31:0] f1, input logic [31:0] f2);
        write_reg(CFG_ENABLED, {31'd0, en});
        write_reg(CFG_ZERO_OFFSET, zo);
        write_reg(CFG_READING_0, c0);
        write_reg(CFG_READING_1, c1);
        write_reg(CFG_READING_2, c2);
        write_reg(CFG_FACTOR_0, f0);
        write_reg(CFG_FACTOR_1, f1);
        write_reg(CFG_FACTOR_2, f2);
    endtask

    task automatic test_reset_state();
        send_reading(24'sd0);
        send_reading(24'sh7FFFFF);
        drain();
        write_reg(CFG_ENABLED, 32'd1);
        send_reading(24'sd0);
        send_reading(24'sd1000);
        send_reading(24'sh800000);
        drain();
    endtask

    task automatic test_coincident();
        load_all(1'b1, 0, 32'd100, 32'd100, 32'd300, 32'd65536, 32'd65536, 32'd65536);
        send_reading(24'sd5);
        drain();
        load_all(1'b1, 0, 32'd100, 32'd200, 32'd200, 32'd65536, 32'd65536, 32'd65536);
        send_reading(24'sd5);
        drain();
    endtask

    task automatic test_zero_factor();
        load_all(1'b1, 0, 32'd0, 32'd1000, 32'd2000, 32'd0, 32'd0, 32'd0);
        send_reading(24'sd500);
        drain();
        load_all(1'b1, 0, 32'd0, 32'd1000, 32'd2000, 32'd65536, 32'd0, 32'd65536);
        send_reading(24'sd1000);
        send_reading(24'sd999);
        drain();
    endtask

    task automatic test_saturation();
        load_all(1'b1, 32'hFF800000, 32'd0, 32'd1, 32'd2, 32'd1, 32'd1, 32'd1);
        send_reading(24'sh7FFFFF);
        send_reading(24'sh800000);
        drain();
        load_all(1'b1, 0, 32'hFF800000, 32'd0, 32'h7FFFFF, 32'h7FFFFFFF, 32'h80000000,
                 32'h7FFFFFFF);
        send_reading(24'sh7FFFFF);
        send_reading(24'sh800000);
        send_reading(24'sd0);
        drain();
    endtask

    task automatic test_extremes();
        load_all(1'b1, 32'h7FFFFF, 32'h800000, 32'd0, 32'h7FFFFF, 32'h01000000,
                 32'h00800000, 32'h02000000);
        send_reading(24'sh800000);
        send_reading(24'sh7FFFFF);
        send_reading(24'sd0);
        send_reading(-24'sd1);
        drain();
        write_reg(CFG_ENABLED, 32'd0);
        send_reading(24'sd123);
        drain();
    endtask

    task automatic random_config(input int phase);
        logic [31:0] f;
        int          sp;
        sp = (phase % 3 == 0) ? 23 : $urandom_range(4, 22);
        f = $urandom_range(1 << 12, 1 << 24);
        if (phase % 4 == 3)
            load_all(1'($urandom), $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom);
        else
            load_all(($urandom_range(0, 9) != 0), $urandom_range(0, 1 << sp) - (1 << (sp - 1)),
                     -($urandom_range(1, 1 << sp)), $urandom_range(0, 1 << (sp - 1)),
                     $urandom_range(1 << sp, 8388607),
                     f + $urandom_range(0, 1 << 14), f + $urandom_range(0, 1 << 14),
                     f + $urandom_range(0, 1 << 14));
    endtask

    task automatic test_random();
        int burst;
        for (int phase = 0; phase < 12; phase++)
        begin
            random_config(phase);
            for (int i = 0; i < 140; )
            begin
                burst = $urandom_range(1, 24);
                for (int k = 0; k < burst && i < 140; k++, i++)
                    send_reading(ADC_W'($urandom));
                if ($urandom_range(0, 3) != 0)
                    pause($urandom_range(1, 6));
            end
            drain();
        end
    endtask

    initial
    begin
        mismatches = 0;
        cycles = 0;
        reg_en = 1'b0;
        reg_zero = '0;
        reg_rd[0] = 24'sd0;
        reg_rd[1] = 24'sd1;
        reg_rd[2] = 24'sd2;
        for (int i = 0; i < 3; i++)
            reg_fac[i] = 32'sd65536;
        rst_n <= 1'b0;
        start <= 1'b0;
        adc_average <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_coincident();
        test_zero_factor();
        test_saturation();
        test_extremes();
        test_random();
        drain();
        if (mismatches == 0 && pending_masses.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
